[sv/jet_pkg.sv]
// ============================================================================
// jet_pkg - shared types and constants of the Julia escape-time unit
// Item structs, register indexes and the fixed-point helper functions.
// ============================================================================
package jet_pkg;

    localparam int COUNT_BITS    = 16;
    localparam int PIXEL_BITS    = 12;
    localparam int FRACTION_BITS = 28;

    localparam int WORD_BITS  = 32;
    localparam int STEP_BITS  = 31;
    localparam int LIMIT_BITS = 16;
    localparam int PROD_BITS  = 2 * WORD_BITS;
    localparam int INDEX_BITS = 3;

    localparam logic signed [PROD_BITS-1:0] WORD_MAX = 64'sd2147483647;
    localparam logic signed [PROD_BITS-1:0] WORD_MIN = -64'sd2147483648;
    localparam logic signed [PROD_BITS-1:0] FOUR     = 64'sd4 <<< FRACTION_BITS;
    localparam logic [32:0] COUNT_MAX = (33'd1 << COUNT_BITS) - 33'd1;

    typedef enum logic [INDEX_BITS-1:0] {
        CFG_C_REAL      = 3'd0,
        CFG_C_IMAG      = 3'd1,
        CFG_ITER_LIMIT  = 3'd2,
        CFG_REAL_ORIGIN = 3'd3,
        CFG_IMAG_ORIGIN = 3'd4,
        CFG_REAL_STEP   = 3'd5,
        CFG_IMAG_STEP   = 3'd6
    } t_cfg_index;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel_col;
        logic [PIXEL_BITS-1:0] pixel_row;
    } t_pixel;

    typedef struct packed {
        logic [COUNT_BITS-1:0] iter_count;
        logic                  escaped;
        logic [PIXEL_BITS-1:0] col_echo;
        logic [PIXEL_BITS-1:0] row_echo;
    } t_result;

    // clamp a wide signed value into one data word
    function automatic logic signed [WORD_BITS-1:0] sat_word(
        input logic signed [PROD_BITS-1:0] v
    );
        logic signed [PROD_BITS-1:0] c;
        c = v;
        if (v > WORD_MAX) begin
            c = WORD_MAX;
        end else if (v < WORD_MIN) begin
            c = WORD_MIN;
        end
        return c[WORD_BITS-1:0];
    endfunction

    // drop the fraction bits of a raw product, rounding toward minus infinity
    function automatic logic signed [PROD_BITS-1:0] fx_shift(
        input logic signed [PROD_BITS-1:0] p
    );
        return p >>> FRACTION_BITS;
    endfunction

    // clamp a pass count to the result field
    function automatic logic [COUNT_BITS-1:0] sat_count(input logic [LIMIT_BITS-1:0] v);
        logic [32:0] w;
        w = {{(33-LIMIT_BITS){1'b0}}, v};
        if (w > COUNT_MAX) begin
            w = COUNT_MAX;
        end
        return w[COUNT_BITS-1:0];
    endfunction

endpackage

[sv/julia_escape_time.sv]
// ============================================================================
// julia_escape_time - escape-time iteration for one Julia-set pixel
// Maps a pixel to a complex start point and iterates z = z*z + c.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in) carries one pixel item
//   (column, row). An item is taken at a clock edge with valid high and
//   stall low. The block works on one pixel at a time and holds o_in_stall
//   high from the accept until the pixel's result has been moved into the
//   output register.
//   Output channel (o_out_valid / i_out_stall / o_out) carries one result
//   item per pixel: pass count, escaped flag and the pixel coordinate.
//   A result waits in the output register while the receiver stalls; the
//   next pixel is still accepted and worked on, and it waits at its end
//   until the output register is free.
//   A zero limit skips the passes and hands the result over right after
//   mapping; the default limit is 256. The one 32x32 multiplier forms both
//   squares and the cross product of every pass in turn, followed by the
//   update.
//   Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index at
//   once; write only while no pixel is in flight. Index 7 is ignored.
//   Reset (synchronous, active low) loads the default view and constant,
//   empties the output register and returns the sequencer to idle.
// ============================================================================
module julia_escape_time (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [jet_pkg::INDEX_BITS-1:0]        i_cfg_index,
    input  logic [jet_pkg::WORD_BITS-1:0]         i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  jet_pkg::t_pixel                       i_in,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output jet_pkg::t_result                      o_out
);
    import jet_pkg::*;

    // sequencer: each state names the multiply it issues or the step it takes
    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,  // wait for a pixel
        S_MAPR = 8'b0000_0010,  // col * real_step
        S_MAPI = 8'b0000_0100,  // row * imag_step, store real start
        S_MAGR = 8'b0000_1000,  // re * re (store imag start on first pass)
        S_MAGI = 8'b0001_0000,  // im * im, keep re^2
        S_TEST = 8'b0010_0000,  // escape test, re * im for the next pass
        S_UPD  = 8'b0100_0000,  // new re and im
        S_DONE = 8'b1000_0000   // hand the result to the output register
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic signed [WORD_BITS-1:0] r_c_real, r_c_imag, r_real_origin, r_imag_origin;
    logic [LIMIT_BITS-1:0]       r_limit;
    logic [STEP_BITS-1:0]        r_real_step, r_imag_step;

    // working registers
    logic [PIXEL_BITS-1:0]       r_col, r_row;
    logic signed [WORD_BITS-1:0] r_re, r_im, r_rr, r_ii;
    logic signed [PROD_BITS-1:0] r_rr_full, r_prod;
    logic [LIMIT_BITS-1:0]       r_pass;
    logic                        r_first, r_esc;
    logic                        r_out_valid;
    t_result                     r_out;

    // shared multiplier operands
    logic signed [WORD_BITS-1:0] mul_a, mul_b;
    logic signed [PROD_BITS-1:0] mul_p;

    logic                        in_accept;
    logic                        out_free;
    logic signed [PROD_BITS-1:0] map_re_sum, map_im_sum;
    logic signed [PROD_BITS-1:0] ii_full, mag;
    logic signed [PROD_BITS-1:0] nr_sum, ni_sum;
    logic                        escape_now;
    logic                        last_pass;

    assign in_accept = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;

    // start point: origin plus pixel times step, both sides use r_prod
    assign map_re_sum = PROD_BITS'(r_real_origin) + r_prod;
    assign map_im_sum = PROD_BITS'(r_imag_origin) + r_prod;

    // escape test on the squares of the freshly updated point
    assign ii_full    = fx_shift(r_prod);
    assign mag        = r_rr_full + ii_full;
    assign escape_now = (mag > FOUR);
    assign last_pass  = (({1'b0, r_pass} + 17'd1) == {1'b0, r_limit});

    // pass update: r_prod holds re*im here
    assign nr_sum = PROD_BITS'(r_rr) - PROD_BITS'(r_ii) + PROD_BITS'(r_c_real);
    assign ni_sum = (PROD_BITS'(sat_word(fx_shift(r_prod))) <<< 1) + PROD_BITS'(r_c_imag);

    // operand select for the one multiplier
    always_comb begin
        mul_a = r_re;
        mul_b = r_im;
        unique case (r_state) inside
            S_IDLE: begin
                mul_a = signed'(WORD_BITS'(i_in.pixel_col));
                mul_b = signed'(WORD_BITS'(r_real_step));
            end
            S_MAPR: begin
                mul_a = signed'(WORD_BITS'(r_col));
                mul_b = signed'(WORD_BITS'(r_real_step));
            end
            S_MAPI: begin
                mul_a = signed'(WORD_BITS'(r_row));
                mul_b = signed'(WORD_BITS'(r_imag_step));
            end
            S_MAGR: begin
                mul_a = r_re;
                mul_b = r_re;
            end
            S_MAGI: begin
                mul_a = r_im;
                mul_b = r_im;
            end
            S_TEST, S_UPD, S_DONE: begin
                mul_a = r_re;
                mul_b = r_im;
            end
            default: begin
                mul_a = r_re;
                mul_b = r_im;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) n_state = S_MAPR;
            end
            S_MAPR: n_state = S_MAPI;
            S_MAPI: begin
                n_state = (r_limit == '0) ? S_DONE : S_MAGR;
            end
            S_MAGR: n_state = S_MAGI;
            S_MAGI: n_state = S_TEST;
            S_TEST: begin
                if (r_first) begin
                    n_state = S_UPD;
                end else if (escape_now || last_pass) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_UPD;
                end
            end
            S_UPD: n_state = S_MAGR;
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_c_real      <= -32'sd201326592;
            r_c_imag      <= 32'sd6714913;
            r_limit       <= 16'd256;
            r_real_origin <= -32'sd402653184;
            r_imag_origin <= -32'sd268435456;
            r_real_step   <= 31'd2013266;
            r_imag_step   <= 31'd894785;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_C_REAL:      r_c_real      <= signed'(i_cfg_data);
                    CFG_C_IMAG:      r_c_imag      <= signed'(i_cfg_data);
                    CFG_ITER_LIMIT:  r_limit       <= i_cfg_data[LIMIT_BITS-1:0];
                    CFG_REAL_ORIGIN: r_real_origin <= signed'(i_cfg_data);
                    CFG_IMAG_ORIGIN: r_imag_origin <= signed'(i_cfg_data);
                    CFG_REAL_STEP:   r_real_step   <= i_cfg_data[STEP_BITS-1:0];
                    CFG_IMAG_STEP:   r_imag_step   <= i_cfg_data[STEP_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    r_col   <= i_in.pixel_col;
                    r_row   <= i_in.pixel_row;
                    r_pass  <= '0;
                    r_first <= 1'b1;
                    r_esc   <= 1'b0;
                end
            end
            S_MAPR: ;
            S_MAPI: begin
                r_re <= sat_word(map_re_sum);
            end
            S_MAGR: begin
                if (r_first) r_im <= sat_word(map_im_sum);
            end
            S_MAGI: begin
                r_rr_full <= fx_shift(r_prod);
            end
            S_TEST: begin
                // squares of this point are the next pass's re^2 and im^2
                r_rr <= sat_word(r_rr_full);
                r_ii <= sat_word(ii_full);
                if (r_first) begin
                    r_first <= 1'b0;
                end else if (escape_now) begin
                    r_esc <= 1'b1;
                end else begin
                    r_pass <= r_pass + LIMIT_BITS'(1);
                end
            end
            S_UPD: begin
                r_re <= sat_word(nr_sum);
                r_im <= sat_word(ni_sum);
            end
            S_DONE: begin
                if (out_free) begin
                    r_out.iter_count <= sat_count(r_pass);
                    r_out.escaped    <= r_esc;
                    r_out.col_echo   <= r_col;
                    r_out.row_echo   <= r_row;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // an accepted pixel always starts with the column multiply
    a_accept_maps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_MAPR))
        else $error("accepted pixel did not start mapping");

    // the escape test always follows the imaginary square
    a_test_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TEST) |-> ($past(r_state) == S_MAGI))
        else $error("escape test out of order");

    // a new result is loaded only from the hand-off state
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid)) |-> ($past(r_state) == S_DONE))
        else $error("result appeared without hand-off");

    // the update never runs before the first squares are in place
    a_upd_after_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> !r_first)
        else $error("update before first squares");

endmodule
